FILE: hw/rtl/qvr_pkg.sv
// Shared types and constants of the quaternion point rotation block.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

  // Coordinate width default.
  localparam int unsigned COORD_BITS_DEFAULT = 24;

  // Rotation quaternion components are signed Q2.14.
  localparam int unsigned ROT_BITS = 16;
  localparam int unsigned PROD_BITS = 2 * ROT_BITS;
  // Matrix entries hold sums of up to four products, times two for off-diagonal terms.
  localparam int unsigned MAT_BITS = PROD_BITS + 2;
  // Binary point of the matrix entries.
  localparam int unsigned QFRAC = 28;

  // Configuration port.
  localparam int unsigned CFG_IDX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROT_W = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_ROT_X = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_ROT_Y = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_ROT_Z = CFG_IDX_BITS'(3);

  // Reset quaternion is the identity, 1.0 in Q2.14.
  localparam logic [ROT_BITS-1:0] ROT_W_RESET = ROT_BITS'(16384);
  localparam logic [ROT_BITS-1:0] ROT_ZERO = '0;
  localparam logic [PROD_BITS-1:0] SQ_W_RESET = PROD_BITS'(32'd268435456);
  localparam logic [MAT_BITS-1:0] MAT_DIAG_RESET = MAT_BITS'(32'd268435456);

  typedef logic [MAT_BITS-1:0] mat_elem_t;

  // One configuration write as seen by the matrix unit.
  typedef struct packed {
    logic                     valid;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } qvr_cfg_wr_t;

  // Load enables of the three point pipeline stages.
  typedef struct packed {
    logic mul;
    logic sum;
    logic rnd;
  } qvr_stage_en_t;

endpackage

`default_nettype wire

FILE: hw/rtl/qvr_if.sv
// Valid/ready channel interfaces for points, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface qvr_point_if
  import qvr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [COORD_BITS-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface qvr_result_if
  import qvr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [COORD_BITS-1:0] out_z;
  logic                  saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

interface qvr_cfg_if
  import qvr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/quaternion_vector_rotate_top.sv
// Top level of the quaternion point rotation block.
`timescale 1ns / 1ps
`default_nettype none

// Rotates a stream of 3-D points by the quaternion held in four registers.
// Channels: cfg_if writes rot_w, rot_x, rot_y, rot_z (indexes 0 to 3, Q2.14,
// other indexes are dropped); in_if carries one point per word; out_if
// carries the rotated point and a flag that is set when any coordinate clipped.
// Throughput is one word per cycle while out_if is ready and no write is settling.
// An accepted point passes through these stages in order before it is on out_if:
// one stage of multipliers, one stage of adders, one stage of rounding and
// saturation that is also the output register.
// Each stage holds a valid bit; a stage refills whenever it is empty or its
// successor moves, so a stalled receiver fills the pipe and then drops in_if.ready
// without losing or repeating a word.
// The rotation matrix is rebuilt from the registers through the product and
// entry registers after a write; in_if.ready is held low while settle_q is set so
// no point meets a half-built matrix. cfg_if is always ready.
// Reset clears the pipeline and restores the identity quaternion.
module quaternion_vector_rotate_top
  import qvr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qvr_cfg_if.sink    cfg_if,
  qvr_point_if.sink  in_if,
  qvr_result_if.source out_if
);

  qvr_cfg_wr_t   cfg_wr;
  mat_elem_t     mat [3][3];
  qvr_stage_en_t stage_en;

  logic [1:0] settle_q;
  logic mul_vld_q, sum_vld_q, rnd_vld_q;
  logic mul_rdy, sum_rdy, rnd_rdy;
  logic in_fire;

  logic [2:0][COORD_BITS-1:0] vec;
  logic [2:0][COORD_BITS-1:0] coord;
  logic [2:0]                 sat;

  // Configuration writes are taken in every cycle.
  assign cfg_if.ready = 1'b1;
  assign cfg_wr.valid = cfg_if.valid;
  assign cfg_wr.index = cfg_if.index;
  assign cfg_wr.data  = cfg_if.data;

  qvr_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_wr),
    .mat_o  (mat)
  );

  // After a write the quaternion, product and matrix entry registers update in that order.
  // The two bits track the product and entry updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
    end else begin
      settle_q <= {settle_q[0], cfg_if.valid};
    end
  end

  // A stage can take a word when it is empty or its contents move on.
  assign rnd_rdy = !rnd_vld_q || out_if.ready;
  assign sum_rdy = !sum_vld_q || rnd_rdy;
  assign mul_rdy = !mul_vld_q || sum_rdy;

  assign in_if.ready = mul_rdy && !(|settle_q);
  assign in_fire     = in_if.valid && in_if.ready;

  assign stage_en.mul = in_fire;
  assign stage_en.sum = mul_vld_q && sum_rdy;
  assign stage_en.rnd = sum_vld_q && rnd_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
      rnd_vld_q <= 1'b0;
    end else begin
      if (mul_rdy) begin
        mul_vld_q <= in_fire;
      end
      if (sum_rdy) begin
        sum_vld_q <= mul_vld_q;
      end
      if (rnd_rdy) begin
        rnd_vld_q <= sum_vld_q;
      end
    end
  end

  assign vec[0] = in_if.point_x;
  assign vec[1] = in_if.point_y;
  assign vec[2] = in_if.point_z;

  // One row unit per output coordinate.
  for (genvar k = 0; k < 3; k++) begin : g_row
    qvr_row #(
      .COORD_BITS (COORD_BITS)
    ) u_row (
      .clk_i   (clk_i),
      .en_i    (stage_en),
      .row_i   (mat[k]),
      .vec_i   (vec),
      .coord_o (coord[k]),
      .sat_o   (sat[k])
    );
  end

  assign out_if.valid     = rnd_vld_q;
  assign out_if.out_x     = coord[0];
  assign out_if.out_y     = coord[1];
  assign out_if.out_z     = coord[2];
  assign out_if.saturated = |sat;

  // A configuration write keeps the next point out while the rotation matrix settles.
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_if.valid |=> !in_if.ready ##1 !in_if.ready)
    else $error("point accepted while the rotation matrix was settling");

  // A word in the multiplier stage that may advance reaches the adder stage.
  a_mul_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_vld_q && sum_rdy) |=> sum_vld_q)
    else $error("word lost between multiplier and adder stages");

  // A word in the adder stage that may advance reaches the output register.
  a_sum_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_vld_q && rnd_rdy) |=> out_if.valid)
    else $error("word lost between adder stage and output register");

  // A point accepted into an empty pipeline moves on from the multiplier stage to
  // the adder stage.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !mul_vld_q && !sum_vld_q && !rnd_vld_q) |=> ##1 sum_vld_q)
    else $error("accepted point did not advance through an empty pipeline");

endmodule

`default_nettype wire

FILE: hw/rtl/qvr_matrix.sv
// Rotation quaternion registers and the derived 3x3 rotation matrix.
`timescale 1ns / 1ps
`default_nettype none

module qvr_matrix
  import qvr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire qvr_cfg_wr_t wr_i,
  output mat_elem_t        mat_o [3][3]
);

  logic [ROT_BITS-1:0] rot_w_q, rot_x_q, rot_y_q, rot_z_q;

  // Ten distinct products of the components, registered before the sums.
  logic signed [PROD_BITS-1:0] ww_d, xx_d, yy_d, zz_d, xy_d, wz_d, xz_d, wy_d, yz_d, wx_d;
  logic signed [PROD_BITS-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;

  mat_elem_t mat_d [3][3];
  mat_elem_t mat_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_w_q <= ROT_W_RESET;
      rot_x_q <= ROT_ZERO;
      rot_y_q <= ROT_ZERO;
      rot_z_q <= ROT_ZERO;
    end else if (wr_i.valid) begin
      case (wr_i.index)
        REG_ROT_W: rot_w_q <= wr_i.data[ROT_BITS-1:0];
        REG_ROT_X: rot_x_q <= wr_i.data[ROT_BITS-1:0];
        REG_ROT_Y: rot_y_q <= wr_i.data[ROT_BITS-1:0];
        REG_ROT_Z: rot_z_q <= wr_i.data[ROT_BITS-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [PROD_BITS-1:0] smul(input logic [ROT_BITS-1:0] a,
                                                       input logic [ROT_BITS-1:0] b);
    smul = PROD_BITS'($signed(a)) * PROD_BITS'($signed(b));
  endfunction

  function automatic logic signed [MAT_BITS-1:0] sx(input logic signed [PROD_BITS-1:0] p);
    sx = MAT_BITS'(p);
  endfunction

  always_comb begin
    ww_d = smul(rot_w_q, rot_w_q);
    xx_d = smul(rot_x_q, rot_x_q);
    yy_d = smul(rot_y_q, rot_y_q);
    zz_d = smul(rot_z_q, rot_z_q);
    xy_d = smul(rot_x_q, rot_y_q);
    wz_d = smul(rot_w_q, rot_z_q);
    xz_d = smul(rot_x_q, rot_z_q);
    wy_d = smul(rot_w_q, rot_y_q);
    yz_d = smul(rot_y_q, rot_z_q);
    wx_d = smul(rot_w_q, rot_x_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ww_q <= SQ_W_RESET;
      xx_q <= '0;
      yy_q <= '0;
      zz_q <= '0;
      xy_q <= '0;
      wz_q <= '0;
      xz_q <= '0;
      wy_q <= '0;
      yz_q <= '0;
      wx_q <= '0;
    end else begin
      ww_q <= ww_d;
      xx_q <= xx_d;
      yy_q <= yy_d;
      zz_q <= zz_d;
      xy_q <= xy_d;
      wz_q <= wz_d;
      xz_q <= xz_d;
      wy_q <= wy_d;
      yz_q <= yz_d;
      wx_q <= wx_d;
    end
  end

  always_comb begin
    mat_d[0][0] = sx(ww_q) + sx(xx_q) - sx(yy_q) - sx(zz_q);
    mat_d[0][1] = (sx(xy_q) - sx(wz_q)) <<< 1;
    mat_d[0][2] = (sx(xz_q) + sx(wy_q)) <<< 1;
    mat_d[1][0] = (sx(xy_q) + sx(wz_q)) <<< 1;
    mat_d[1][1] = sx(ww_q) - sx(xx_q) + sx(yy_q) - sx(zz_q);
    mat_d[1][2] = (sx(yz_q) - sx(wx_q)) <<< 1;
    mat_d[2][0] = (sx(xz_q) - sx(wy_q)) <<< 1;
    mat_d[2][1] = (sx(yz_q) + sx(wx_q)) <<< 1;
    mat_d[2][2] = sx(ww_q) - sx(xx_q) - sx(yy_q) + sx(zz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mat_q[r][c] <= (r == c) ? MAT_DIAG_RESET : '0;
        end
      end
    end else begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

`default_nettype wire

FILE: hw/rtl/qvr_row.sv
// One output coordinate: row-times-vector products, sums, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module qvr_row
  import qvr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire qvr_stage_en_t                  en_i,
  input  wire mat_elem_t                      row_i [3],
  input  wire logic [2:0][COORD_BITS-1:0]     vec_i,
  output logic        [COORD_BITS-1:0]        coord_o,
  output logic                                sat_o
);

  // Each coordinate is split into an unsigned low half and a signed high half
  // so that each multiplier takes the matrix entry and at most LB + 1 coordinate bits.
  localparam int unsigned LB  = COORD_BITS / 2;
  localparam int unsigned HB  = COORD_BITS - LB;
  localparam int unsigned LPW = MAT_BITS + LB + 1;
  localparam int unsigned HPW = MAT_BITS + HB;
  localparam int unsigned SLW = LPW + 2;
  localparam int unsigned SHW = HPW + 2;
  localparam int unsigned TW  = MAT_BITS + HB + 5;

  localparam logic signed [TW-1:0] RoundBias = TW'(1) <<< (QFRAC - 1 - LB);
  localparam logic signed [TW-1:0] CoordMax  = (TW'(1) <<< (COORD_BITS - 1)) - TW'(1);
  localparam logic signed [TW-1:0] CoordMin  = -CoordMax - TW'(1);

  logic signed [LPW-1:0] lo_prod_d [3];
  logic signed [LPW-1:0] lo_prod_q [3];
  logic signed [HPW-1:0] hi_prod_d [3];
  logic signed [HPW-1:0] hi_prod_q [3];
  logic signed [SLW-1:0] slo_d, slo_q;
  logic signed [SHW-1:0] shi_d, shi_q;
  logic signed [SLW-1:0] lo_floor;
  logic signed [TW-1:0]  total;
  logic signed [TW-1:0]  rounded;
  logic                  over, under;
  logic [COORD_BITS-1:0] coord_d, coord_q;
  logic                  sat_d, sat_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_prod_d[i] = LPW'($signed(row_i[i])) * LPW'($signed({1'b0, vec_i[i][LB-1:0]}));
      hi_prod_d[i] = HPW'($signed(row_i[i])) * HPW'($signed(vec_i[i][COORD_BITS-1:LB]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      lo_prod_q <= lo_prod_d;
      hi_prod_q <= hi_prod_d;
    end
  end

  assign slo_d = SLW'(lo_prod_q[0]) + SLW'(lo_prod_q[1]) + SLW'(lo_prod_q[2]);
  assign shi_d = SHW'(hi_prod_q[0]) + SHW'(hi_prod_q[1]) + SHW'(hi_prod_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      slo_q <= slo_d;
      shi_q <= shi_d;
    end
  end

  // The exact sum is shi * 2^LB + slo. Dropping the low LB bits of slo does not
  // change the floor taken after adding the half-unit bias.
  always_comb begin
    lo_floor = slo_q >>> LB;
    total    = TW'(shi_q) + TW'(lo_floor) + RoundBias;
    rounded  = total >>> (QFRAC - LB);
    over     = rounded > CoordMax;
    under    = rounded < CoordMin;
    sat_d    = over | under;
    if (over) begin
      coord_d = CoordMax[COORD_BITS-1:0];
    end else if (under) begin
      coord_d = CoordMin[COORD_BITS-1:0];
    end else begin
      coord_d = rounded[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.rnd) begin
      coord_q <= coord_d;
      sat_q   <= sat_d;
    end
  end

  assign coord_o = coord_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire
